// ----- rtl/edmt_pkg.sv -----
// shared types and constants of the egg drop minimum trials block
`default_nettype none
package edmt_pkg;

  // default limits
  localparam int MAX_EGGS_DEF   = 8;
  localparam int MAX_FLOORS_DEF = 255;

  // field widths
  localparam int EGGS_W   = 4;
  localparam int FLOORS_W = 8;
  localparam int TRIALS_W = 8;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW1,
    ST_NEXT_ROW,
    ST_INIT0,
    ST_INIT1,
    ST_SCAN,
    ST_DRAIN,
    ST_COL_WR,
    ST_FINAL_RD,
    ST_FINAL_WAIT
  } edmt_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic row1_wr;
    logic row_next;
    logic init0_wr;
    logic init1_wr;
    logic scan;
    logic col_wr;
    logic final_rd;
    logic capture;
  } edmt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic col_last;
    logic x_last;
    logic row_last;
    logic one_egg;
    logic k_zero;
    logic k_lt2;
  } edmt_status_t;

endpackage
`default_nettype wire

// ----- rtl/edmt_dp.sv -----
// datapath: row memories, counters and running minimum
`default_nettype none
module edmt_dp #(
  parameter int MAX_EGGS   = edmt_pkg::MAX_EGGS_DEF,
  parameter int MAX_FLOORS = edmt_pkg::MAX_FLOORS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire  [edmt_pkg::EGGS_W-1:0]      in_eggs,
  input  wire  [edmt_pkg::FLOORS_W-1:0]    in_floors,
  input  wire  edmt_pkg::edmt_cmd_t        cmd,
  output edmt_pkg::edmt_status_t           status,
  output logic [edmt_pkg::TRIALS_W-1:0]    out_min_trials
);

  localparam int DEPTH = MAX_FLOORS + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = $clog2(MAX_EGGS + 1);
  localparam int TW    = edmt_pkg::TRIALS_W;

  // row memories, used in ping-pong fashion
  logic [TW-1:0] mem0 [DEPTH];
  logic [TW-1:0] mem1 [DEPTH];

  logic [EW-1:0] n_r, i_r;
  logic [AW-1:0] k_r, j_r, x_r;
  logic          cur_sel_r;
  logic          rd_vld_r;
  logic [TW-1:0] rd0_r, rd1_r;
  logic [TW:0]   best_r;
  logic [TW-1:0] trials_r;

  logic [EW-1:0] n_sat;
  logic [AW-1:0] k_sat;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [TW-1:0] wr_data;
  logic [AW-1:0] cur_addr, prev_addr, addr0, addr1;
  logic [TW-1:0] cur_data, prev_data, big;
  logic [TW:0]   cand;

  // clamp the input word to the supported range
  always_comb begin
    if (in_eggs == '0) begin
      n_sat = EW'(1);
    end else if (32'(in_eggs) > MAX_EGGS) begin
      n_sat = EW'(MAX_EGGS);
    end else begin
      n_sat = EW'(in_eggs);
    end
    if (32'(in_floors) > MAX_FLOORS) begin
      k_sat = AW'(MAX_FLOORS);
    end else begin
      k_sat = AW'(in_floors);
    end
  end

  // write port of the current row
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j_r;
    wr_data = TW'(j_r);
    if (cmd.row1_wr) begin
      wr_en = 1'b1;
    end else if (cmd.init0_wr) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = '0;
    end else if (cmd.init1_wr) begin
      wr_en   = 1'b1;
      wr_addr = AW'(1);
      wr_data = TW'(1);
    end else if (cmd.col_wr) begin
      wr_en   = 1'b1;
      wr_data = best_r[TW-1:0];
    end
  end

  // read addresses: current row at j-x (or k at the end), previous row at x-1
  assign cur_addr  = cmd.final_rd ? k_r : (j_r - x_r);
  assign prev_addr = x_r - AW'(1);
  assign addr0     = cur_sel_r ? prev_addr : cur_addr;
  assign addr1     = cur_sel_r ? cur_addr  : prev_addr;

  // memory bank 0
  always_ff @(posedge clk) begin
    if (wr_en && !cur_sel_r) begin
      mem0[wr_addr] <= wr_data;
    end
    rd0_r <= mem0[addr0];
  end

  // memory bank 1
  always_ff @(posedge clk) begin
    if (wr_en && cur_sel_r) begin
      mem1[wr_addr] <= wr_data;
    end
    rd1_r <= mem1[addr1];
  end

  // candidate 1 + max(prev, cur)
  assign cur_data  = cur_sel_r ? rd1_r : rd0_r;
  assign prev_data = cur_sel_r ? rd0_r : rd1_r;
  assign big       = (prev_data > cur_data) ? prev_data : cur_data;
  assign cand      = {1'b0, big} + (TW+1)'(1);

  // counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r <= n_sat;
      k_r <= k_sat;
      i_r <= EW'(1);
      j_r <= '0;
      x_r <= AW'(1);
    end else if (cmd.row1_wr) begin
      j_r <= j_r + AW'(1);
    end else if (cmd.row_next) begin
      i_r <= i_r + EW'(1);
      j_r <= AW'(2);
      x_r <= AW'(1);
    end else if (cmd.scan) begin
      x_r <= x_r + AW'(1);
    end else if (cmd.col_wr) begin
      j_r <= j_r + AW'(1);
      x_r <= AW'(1);
    end
  end

  // bank select and read valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_sel_r <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.load) begin
        cur_sel_r <= 1'b0;
      end else if (cmd.row_next) begin
        cur_sel_r <= ~cur_sel_r;
      end
    end
  end

  // running minimum over x
  always_ff @(posedge clk) begin
    if (cmd.col_wr || cmd.row_next) begin
      best_r <= '1;
    end else if (rd_vld_r && (cand < best_r)) begin
      best_r <= cand;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      trials_r <= cur_data;
    end
  end

  assign out_min_trials = trials_r;

  // status back to the controller
  assign status.col_last = (j_r == k_r);
  assign status.x_last   = (x_r == j_r);
  assign status.row_last = (i_r == n_r);
  assign status.one_egg  = (n_r == EW'(1));
  assign status.k_zero   = (k_r == '0);
  assign status.k_lt2    = (k_r <= AW'(1));

endmodule
`default_nettype wire

// ----- rtl/edmt_ctrl.sv -----
// controller state machine sequencing rows, columns and the min scan
`default_nettype none
module edmt_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire  edmt_pkg::edmt_status_t status,
  output edmt_pkg::edmt_cmd_t          cmd,
  output logic                         busy,
  output logic                         out_strobe
);

  edmt_pkg::edmt_state_t state_r, state_nxt;
  logic                  strobe_r;

  // state register and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= edmt_pkg::ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == edmt_pkg::ST_FINAL_WAIT);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      edmt_pkg::ST_IDLE: begin
        if (start) state_nxt = edmt_pkg::ST_ROW1;
      end
      edmt_pkg::ST_ROW1: begin
        if (status.col_last) begin
          state_nxt = status.one_egg ? edmt_pkg::ST_FINAL_RD : edmt_pkg::ST_NEXT_ROW;
        end
      end
      edmt_pkg::ST_NEXT_ROW: begin
        state_nxt = edmt_pkg::ST_INIT0;
      end
      edmt_pkg::ST_INIT0: begin
        if (status.k_zero) begin
          state_nxt = status.row_last ? edmt_pkg::ST_FINAL_RD : edmt_pkg::ST_NEXT_ROW;
        end else begin
          state_nxt = edmt_pkg::ST_INIT1;
        end
      end
      edmt_pkg::ST_INIT1: begin
        if (status.k_lt2) begin
          state_nxt = status.row_last ? edmt_pkg::ST_FINAL_RD : edmt_pkg::ST_NEXT_ROW;
        end else begin
          state_nxt = edmt_pkg::ST_SCAN;
        end
      end
      edmt_pkg::ST_SCAN: begin
        if (status.x_last) state_nxt = edmt_pkg::ST_DRAIN;
      end
      edmt_pkg::ST_DRAIN: begin
        state_nxt = edmt_pkg::ST_COL_WR;
      end
      edmt_pkg::ST_COL_WR: begin
        if (status.col_last) begin
          state_nxt = status.row_last ? edmt_pkg::ST_FINAL_RD : edmt_pkg::ST_NEXT_ROW;
        end else begin
          state_nxt = edmt_pkg::ST_SCAN;
        end
      end
      edmt_pkg::ST_FINAL_RD: begin
        state_nxt = edmt_pkg::ST_FINAL_WAIT;
      end
      edmt_pkg::ST_FINAL_WAIT: begin
        state_nxt = edmt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = edmt_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      edmt_pkg::ST_IDLE:       cmd.load     = start;
      edmt_pkg::ST_ROW1:       cmd.row1_wr  = 1'b1;
      edmt_pkg::ST_NEXT_ROW:   cmd.row_next = 1'b1;
      edmt_pkg::ST_INIT0:      cmd.init0_wr = 1'b1;
      edmt_pkg::ST_INIT1:      cmd.init1_wr = 1'b1;
      edmt_pkg::ST_SCAN:       cmd.scan     = 1'b1;
      edmt_pkg::ST_DRAIN:      cmd          = '0;
      edmt_pkg::ST_COL_WR:     cmd.col_wr   = 1'b1;
      edmt_pkg::ST_FINAL_RD:   cmd.final_rd = 1'b1;
      edmt_pkg::ST_FINAL_WAIT: cmd.capture  = 1'b1;
      default:                 cmd          = '0;
    endcase
  end

  assign busy       = (state_r != edmt_pkg::ST_IDLE);
  assign out_strobe = strobe_r;

endmodule
`default_nettype wire

// ----- rtl/egg_drop_min_trials.sv -----
// top level of the egg drop minimum trials block
//
// channel  ports                          handshake
// input    in_eggs, in_floors             start high while busy low
// result   out_min_trials                 out_strobe, one cycle, no back pressure
//
// With n eggs (clamped to 1..MAX_EGGS) and k floors (clamped to MAX_FLOORS),
// busy stays high while the rows of the table are filled, and most of that time
// goes to the min scan, one compare per cycle reading one entry from each row.
// Reset is synchronous and active low; it returns the controller to idle.
// The strobe comes in the first cycle with busy low; the value holds until the next result.
`default_nettype none
module egg_drop_min_trials #(
  parameter int MAX_EGGS   = edmt_pkg::MAX_EGGS_DEF,
  parameter int MAX_FLOORS = edmt_pkg::MAX_FLOORS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire  [edmt_pkg::EGGS_W-1:0]      in_eggs,
  input  wire  [edmt_pkg::FLOORS_W-1:0]    in_floors,
  output logic                             out_strobe,
  output logic [edmt_pkg::TRIALS_W-1:0]    out_min_trials
);

  edmt_pkg::edmt_cmd_t    cmd;
  edmt_pkg::edmt_status_t status;

  // sequencer
  edmt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // table rows and min scan
  edmt_dp #(
    .MAX_EGGS   (MAX_EGGS),
    .MAX_FLOORS (MAX_FLOORS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_eggs        (in_eggs),
    .in_floors      (in_floors),
    .cmd            (cmd),
    .status         (status),
    .out_min_trials (out_min_trials)
  );

endmodule
`default_nettype wire

// ----- bench/edmt_checker.sv -----
// checker for the egg drop minimum trials block: predicts each result and compares
`timescale 1ns / 1ps
module edmt_checker (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire                           busy,
  input  wire [edmt_pkg::EGGS_W-1:0]    in_eggs,
  input  wire [edmt_pkg::FLOORS_W-1:0]  in_floors,
  input  wire                           out_strobe,
  input  wire [edmt_pkg::TRIALS_W-1:0]  out_min_trials,
  output int                            failures,
  output int                            pending
);

  localparam int EGG_LIMIT   = edmt_pkg::MAX_EGGS_DEF;
  localparam int FLOOR_LIMIT = edmt_pkg::MAX_FLOORS_DEF;

  // one outstanding query and the answer it should produce
  typedef struct {
    logic [edmt_pkg::EGGS_W-1:0]   eggs;
    logic [edmt_pkg::FLOORS_W-1:0] floors;
    logic [edmt_pkg::TRIALS_W-1:0] trials;
  } trials_query_t;

  trials_query_t awaited_trials[$];
  int fail_count = 0;

  // scratch rows of the egg-floor table: one egg fewer, and the row being filled
  logic [edmt_pkg::TRIALS_W-1:0] fewer_egg_row [0:FLOOR_LIMIT];
  logic [edmt_pkg::TRIALS_W-1:0] this_egg_row  [0:FLOOR_LIMIT];

  // fill the table row by row and read off the entry for the requested floors
  task automatic predict_trials(input logic [edmt_pkg::EGGS_W-1:0] eggs_in,
                                input logic [edmt_pkg::FLOORS_W-1:0] floors_in,
                                output logic [edmt_pkg::TRIALS_W-1:0] trials);
    int n;
    int k;
    int best;
    int cand;
    int lo;
    int hi;
    n = int'(eggs_in);
    k = int'(floors_in);
    // out-of-range egg and floor counts saturate
    if (n < 1) n = 1;
    if (n > EGG_LIMIT) n = EGG_LIMIT;
    if (k > FLOOR_LIMIT) k = FLOOR_LIMIT;
    // single egg: one trial per floor
    for (int j = 0; j <= k; j++) this_egg_row[j] = j[edmt_pkg::TRIALS_W-1:0];
    for (int i = 2; i <= n; i++) begin
      for (int j = 0; j <= k; j++) fewer_egg_row[j] = this_egg_row[j];
      this_egg_row[0] = '0;
      if (k >= 1) this_egg_row[1] = 8'd1;
      for (int j = 2; j <= k; j++) begin
        best = 32'h7fff_ffff;
        // drop from floor x: breaks -> below with one egg fewer, survives -> above
        for (int x = 1; x <= j; x++) begin
          lo = int'(fewer_egg_row[x-1]);
          hi = int'(this_egg_row[j-x]);
          cand = 1 + ((lo > hi) ? lo : hi);
          if (cand < best) best = cand;
        end
        this_egg_row[j] = best[edmt_pkg::TRIALS_W-1:0];
      end
    end
    trials = this_egg_row[k];
  endtask

  // compare results first, then log the newly accepted word
  always @(posedge clk) begin : watch
    trials_query_t head;
    trials_query_t fresh;
    if (rst_n) begin
      if (out_strobe) begin
        if (awaited_trials.size() == 0) begin
          $display("%0t: unexpected result, expected none, got min_trials %0d",
                   $time, out_min_trials);
          fail_count++;
        end else begin
          head = awaited_trials.pop_front();
          if (out_min_trials !== head.trials) begin
            $display("%0t: eggs %0d floors %0d: expected min_trials %0d, got %0d",
                     $time, head.eggs, head.floors, head.trials, out_min_trials);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        fresh.eggs   = in_eggs;
        fresh.floors = in_floors;
        predict_trials(in_eggs, in_floors, fresh.trials);
        awaited_trials.push_back(fresh);
      end
    end
    failures <= fail_count;
    pending  <= awaited_trials.size();
  end

endmodule

// ----- bench/testbench.sv -----
// top of the egg drop minimum trials bench: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module testbench;

  localparam int STALL_LIMIT = 1_200_000;
  localparam int DRAIN_CYCLES = 20;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic [edmt_pkg::EGGS_W-1:0]   in_eggs = '0;
  logic [edmt_pkg::FLOORS_W-1:0] in_floors = '0;
  logic                          busy;
  logic                          out_strobe;
  logic [edmt_pkg::TRIALS_W-1:0] out_min_trials;
  int                            failures;
  int                            pending;
  int                            stall_cycles = 0;
  bit                            sender_idles = 1'b1;

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  egg_drop_min_trials u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_eggs        (in_eggs),
    .in_floors      (in_floors),
    .out_strobe     (out_strobe),
    .out_min_trials (out_min_trials)
  );

  edmt_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_eggs        (in_eggs),
    .in_floors      (in_floors),
    .out_strobe     (out_strobe),
    .out_min_trials (out_min_trials),
    .failures       (failures),
    .pending        (pending)
  );

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // offer one query word, dropping start on random cycles while sender_idles is set, until it is taken
  task automatic send_query(input logic [edmt_pkg::EGGS_W-1:0] eggs,
                            input logic [edmt_pkg::FLOORS_W-1:0] floors);
    bit offer;
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      offer = !sender_idles || ($urandom_range(99) >= 32);
      start <= offer;
      if (offer) begin
        in_eggs   <= eggs;
        in_floors <= floors;
      end
      @(posedge clk);
      taken = offer && !busy;
    end
  endtask

  initial begin
    int mix;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero and one floor, saturated egg counts, full floor range
    send_query(4'd1, 8'd0);
    send_query(4'd0, 8'd0);
    send_query(4'd8, 8'd0);
    send_query(4'd15, 8'd0);
    send_query(4'd1, 8'd1);
    send_query(4'd2, 8'd1);
    send_query(4'd8, 8'd1);
    send_query(4'd0, 8'd5);
    send_query(4'd1, 8'd255);
    send_query(4'd0, 8'd255);
    send_query(4'd2, 8'd2);
    send_query(4'd2, 8'd3);
    send_query(4'd2, 8'd10);
    send_query(4'd2, 8'd100);
    send_query(4'd3, 8'd14);
    send_query(4'd4, 8'd15);
    send_query(4'd8, 8'd2);
    send_query(4'd15, 8'd7);
    send_query(4'd9, 8'd31);
    send_query(4'd7, 8'd64);
    send_query(4'd3, 8'd128);
    send_query(4'd2, 8'd255);
    send_query(4'd15, 8'd130);
    send_query(4'd8, 8'd255);

    // random: mostly small tables, a few wide ones with few eggs
    for (int w = 0; w < 76; w++) begin
      sender_idles = !(w >= 30 && w < 60);
      mix = int'($urandom_range(99));
      if (mix < 80)
        send_query(4'($urandom_range(15)), 8'($urandom_range(31)));
      else if (mix < 90)
        send_query(4'($urandom_range(4)), 8'($urandom_range(63, 32)));
      else
        send_query(4'($urandom_range(2)), 8'($urandom_range(255)));
    end
    start <= 1'b0;

    // wait for the last results, then a short quiet period
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/edmt_pkg.sv
rtl/edmt_dp.sv
rtl/edmt_ctrl.sv
rtl/egg_drop_min_trials.sv
bench/edmt_checker.sv
bench/testbench.sv
